// File: sv/quaternion_heading_extract_macros.svh
// assertion macros shared by the heading extract rtl
`ifndef QUATERNION_HEADING_EXTRACT_MACROS_SVH
`define QUATERNION_HEADING_EXTRACT_MACROS_SVH

// antecedent implies consequent, consequent may be a delayed sequence
`define QHE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("heading extract: implication check failed");

// expression holds at every clock edge out of reset
`define QHE_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("heading extract: invariant check failed");

`endif

// File: sv/qhe_pkg.sv
// shared types, constants and the arctangent table for the heading extract
`timescale 1ns / 1ps

package qhe_pkg;

   // input sample width and cordic depth
   localparam int SAMPLE_WIDTH = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int TABLE_LEN    = 24;
   localparam int STEPS        = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
   localparam int PROD_SHIFT   = (SAMPLE_WIDTH > 16) ? 2 * (SAMPLE_WIDTH - 16) : 0;

   // datapath widths
   localparam int PROD_W = 2 * SAMPLE_WIDTH;
   localparam int SUM_W  = PROD_W + 1;
   localparam int VEC_W  = SUM_W + 3;
   localparam int ANG_W  = 34;
   localparam int ROT_W  = 34;

   // prod, sum, prerotate, vectoring steps, rotation steps, output
   localparam int LATENCY = 4 + 2 * STEPS;

   // output formatting
   localparam int ANGLE_MAX   = 25736;
   localparam int UNIT_MAX    = 32767;
   localparam int ANGLE_SHIFT = 17;
   localparam int UNIT_SHIFT  = 15;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic signed [PROD_W-1:0]       prod_type;
   typedef logic signed [SUM_W-1:0]        sum_type;
   typedef logic signed [VEC_W-1:0]        vec_type;
   typedef logic signed [ANG_W-1:0]        ang_type;
   typedef logic signed [ROT_W-1:0]        rot_type;

   typedef struct packed {
      logic valid;
      logic degenerate;
   } tag_type;

   localparam ang_type HALF_PI     = ang_type'(32'h6487ED51);
   localparam rot_type INV_GAIN    = rot_type'(32'h26DD3B6A);
   localparam ang_type ANGLE_ROUND = ang_type'(1 << (ANGLE_SHIFT - 1));
   localparam rot_type UNIT_ROUND  = rot_type'(1 << (UNIT_SHIFT - 1));

   // atan(2^-i) in q2.30, truncated
   localparam ang_type ATAN_TAB [TABLE_LEN] = '{
      ang_type'(32'h3243F6A8), ang_type'(32'h1DAC6705), ang_type'(32'h0FADBAFC),
      ang_type'(32'h07F56EA6), ang_type'(32'h03FEAB76), ang_type'(32'h01FFD55B),
      ang_type'(32'h00FFFAAA), ang_type'(32'h007FFF55), ang_type'(32'h003FFFEA),
      ang_type'(32'h001FFFFD), ang_type'(32'h000FFFFF), ang_type'(32'h0007FFFF),
      ang_type'(32'h0003FFFF), ang_type'(32'h0001FFFF), ang_type'(32'h0000FFFF),
      ang_type'(32'h00007FFF), ang_type'(32'h00003FFF), ang_type'(32'h00001FFF),
      ang_type'(32'h00000FFF), ang_type'(32'h000007FF), ang_type'(32'h000003FF),
      ang_type'(32'h000001FF), ang_type'(32'h000000FF), ang_type'(32'h0000007F)
   };

endpackage

// File: sv/qhe_vectoring.sv
// pipelined vectoring cordic, one micro-rotation per register stage
`timescale 1ns / 1ps

module qhe_vectoring (
   input  logic             clock,
   input  logic             reset,
   input  qhe_pkg::tag_type in_tag,
   input  qhe_pkg::vec_type in_x,
   input  qhe_pkg::vec_type in_y,
   input  qhe_pkg::ang_type in_z,
   output qhe_pkg::tag_type out_tag,
   output qhe_pkg::ang_type out_z
);

   qhe_pkg::tag_type tag_ff [qhe_pkg::STEPS];
   qhe_pkg::vec_type x_ff   [qhe_pkg::STEPS];
   qhe_pkg::vec_type y_ff   [qhe_pkg::STEPS];
   qhe_pkg::ang_type z_ff   [qhe_pkg::STEPS];

   for (genvar k = 0; k < qhe_pkg::STEPS; k++) begin : g_step
      qhe_pkg::tag_type tag_cur;
      qhe_pkg::vec_type x_cur;
      qhe_pkg::vec_type y_cur;
      qhe_pkg::ang_type z_cur;
      qhe_pkg::vec_type x_in;
      qhe_pkg::vec_type y_in;
      qhe_pkg::ang_type z_in;

      if (k == 0) begin : g_first
         assign tag_cur = in_tag;
         assign x_cur   = in_x;
         assign y_cur   = in_y;
         assign z_cur   = in_z;
      end else begin : g_next
         assign tag_cur = tag_ff[k-1];
         assign x_cur   = x_ff[k-1];
         assign y_cur   = y_ff[k-1];
         assign z_cur   = z_ff[k-1];
      end

      // y at or above zero turns clockwise
      always_comb begin
         if (!y_cur[qhe_pkg::VEC_W-1]) begin
            x_in = x_cur + (y_cur >>> k);
            y_in = y_cur - (x_cur >>> k);
            z_in = z_cur + qhe_pkg::ATAN_TAB[k];
         end else begin
            x_in = x_cur - (y_cur >>> k);
            y_in = y_cur + (x_cur >>> k);
            z_in = z_cur - qhe_pkg::ATAN_TAB[k];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k].valid <= 1'b0;
         end else begin
            tag_ff[k].valid <= tag_cur.valid;
         end
         tag_ff[k].degenerate <= tag_cur.degenerate;
         x_ff[k]              <= x_in;
         y_ff[k]              <= y_in;
         z_ff[k]              <= z_in;
      end
   end

   assign out_tag = tag_ff[qhe_pkg::STEPS-1];
   assign out_z   = z_ff[qhe_pkg::STEPS-1];

endmodule

// File: sv/qhe_rotation.sv
// pipelined rotation cordic for cosine and sine of the half heading
`timescale 1ns / 1ps

module qhe_rotation (
   input  logic             clock,
   input  logic             reset,
   input  qhe_pkg::tag_type in_tag,
   input  qhe_pkg::ang_type in_ang,
   output qhe_pkg::tag_type out_tag,
   output qhe_pkg::ang_type out_ang,
   output qhe_pkg::rot_type out_cos,
   output qhe_pkg::rot_type out_sin
);

   qhe_pkg::tag_type tag_ff [qhe_pkg::STEPS];
   qhe_pkg::ang_type ang_ff [qhe_pkg::STEPS];
   qhe_pkg::ang_type r_ff   [qhe_pkg::STEPS];
   qhe_pkg::rot_type x_ff   [qhe_pkg::STEPS];
   qhe_pkg::rot_type y_ff   [qhe_pkg::STEPS];

   for (genvar k = 0; k < qhe_pkg::STEPS; k++) begin : g_step
      qhe_pkg::tag_type tag_cur;
      qhe_pkg::ang_type ang_cur;
      qhe_pkg::ang_type r_cur;
      qhe_pkg::rot_type x_cur;
      qhe_pkg::rot_type y_cur;
      qhe_pkg::ang_type r_in;
      qhe_pkg::rot_type x_in;
      qhe_pkg::rot_type y_in;

      if (k == 0) begin : g_first
         // half angle, start vector on the x axis scaled by 1/gain
         assign tag_cur = in_tag;
         assign ang_cur = in_ang;
         assign r_cur   = in_ang >>> 1;
         assign x_cur   = qhe_pkg::INV_GAIN;
         assign y_cur   = '0;
      end else begin : g_next
         assign tag_cur = tag_ff[k-1];
         assign ang_cur = ang_ff[k-1];
         assign r_cur   = r_ff[k-1];
         assign x_cur   = x_ff[k-1];
         assign y_cur   = y_ff[k-1];
      end

      // residual at or above zero turns counter-clockwise
      always_comb begin
         if (!r_cur[qhe_pkg::ANG_W-1]) begin
            x_in = x_cur - (y_cur >>> k);
            y_in = y_cur + (x_cur >>> k);
            r_in = r_cur - qhe_pkg::ATAN_TAB[k];
         end else begin
            x_in = x_cur + (y_cur >>> k);
            y_in = y_cur - (x_cur >>> k);
            r_in = r_cur + qhe_pkg::ATAN_TAB[k];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k].valid <= 1'b0;
         end else begin
            tag_ff[k].valid <= tag_cur.valid;
         end
         tag_ff[k].degenerate <= tag_cur.degenerate;
         ang_ff[k]            <= ang_cur;
         r_ff[k]              <= r_in;
         x_ff[k]              <= x_in;
         y_ff[k]              <= y_in;
      end
   end

   assign out_tag = tag_ff[qhe_pkg::STEPS-1];
   assign out_ang = ang_ff[qhe_pkg::STEPS-1];
   assign out_cos = x_ff[qhe_pkg::STEPS-1];
   assign out_sin = y_ff[qhe_pkg::STEPS-1];

endmodule

// File: sv/quaternion_heading_extract.sv
// top level: heading of an orientation quaternion as a pure yaw quaternion
//
// channel   direction  ports                                     transfer
// request   in         start, busy, req_quat_w/x/y/z             start high, busy low
// result    out        rsp_valid, rsp_yaw_w, rsp_yaw_z,          rsp_valid high, one cycle
//                      rsp_heading_angle, rsp_degenerate
//
// one request per cycle, busy is held low: the pipeline never stops
// results come out in order, via product, sum, prerotate, cordic and output registers
// depth set by one cordic micro-rotation per stage, vectoring then rotation
// synchronous reset clears the valid bits only, data registers are not reset
// the receiver cannot stall, so nothing is held back or repeated
`timescale 1ns / 1ps

`include "quaternion_heading_extract_macros.svh"

module quaternion_heading_extract (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  qhe_pkg::sample_type req_quat_w,
   input  qhe_pkg::sample_type req_quat_x,
   input  qhe_pkg::sample_type req_quat_y,
   input  qhe_pkg::sample_type req_quat_z,
   output logic                rsp_valid,
   output logic        [14:0]  rsp_yaw_w,
   output logic signed [15:0]  rsp_yaw_z,
   output logic signed [15:0]  rsp_heading_angle,
   output logic                rsp_degenerate
);

   // stage 1: the four products of the rotated z axis
   logic              prod_valid_ff;
   qhe_pkg::prod_type prod_xz_ff;
   qhe_pkg::prod_type prod_wy_ff;
   qhe_pkg::prod_type prod_yz_ff;
   qhe_pkg::prod_type prod_wx_ff;

   // stage 2: horizontal projection (half of fx, fy; the factor two leaves the angle alone)
   logic              sum_valid_ff;
   qhe_pkg::sum_type  px_ff;
   qhe_pkg::sum_type  py_ff;

   // stage 3: zero check and quarter-turn into the right half plane
   qhe_pkg::tag_type  pre_tag_ff;
   qhe_pkg::vec_type  pre_x_ff;
   qhe_pkg::vec_type  pre_y_ff;
   qhe_pkg::ang_type  pre_z_ff;
   qhe_pkg::vec_type  px_ext;
   qhe_pkg::vec_type  py_ext;
   qhe_pkg::vec_type  pre_x_in;
   qhe_pkg::vec_type  pre_y_in;
   qhe_pkg::ang_type  pre_z_in;
   logic              pre_degen_in;

   // cordic chains
   qhe_pkg::tag_type  vec_tag;
   qhe_pkg::ang_type  vec_ang;
   qhe_pkg::tag_type  rot_tag;
   qhe_pkg::ang_type  rot_ang;
   qhe_pkg::rot_type  rot_cos;
   qhe_pkg::rot_type  rot_sin;

   // output stage
   qhe_pkg::ang_type  ang_sum;
   qhe_pkg::ang_type  ang_rnd;
   qhe_pkg::rot_type  cos_sum;
   qhe_pkg::rot_type  cos_rnd;
   qhe_pkg::rot_type  sin_sum;
   qhe_pkg::rot_type  sin_rnd;
   logic        [14:0] yaw_w_in;
   logic signed [15:0] yaw_z_in;
   logic signed [15:0] heading_in;
   logic               rsp_valid_ff;
   logic        [14:0] yaw_w_ff;
   logic signed [15:0] yaw_z_ff;
   logic signed [15:0] heading_ff;
   logic               degen_ff;

   // every cycle takes a new request
   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= start && !busy;
         sum_valid_ff  <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_xz_ff <= req_quat_x * req_quat_z;
      prod_wy_ff <= req_quat_w * req_quat_y;
      prod_yz_ff <= req_quat_y * req_quat_z;
      prod_wx_ff <= req_quat_w * req_quat_x;
      px_ff <= qhe_pkg::sum_type'(prod_xz_ff >>> qhe_pkg::PROD_SHIFT)
             + qhe_pkg::sum_type'(prod_wy_ff >>> qhe_pkg::PROD_SHIFT);
      py_ff <= qhe_pkg::sum_type'(prod_yz_ff >>> qhe_pkg::PROD_SHIFT)
             - qhe_pkg::sum_type'(prod_wx_ff >>> qhe_pkg::PROD_SHIFT);
   end

   // a vector in the left half plane is turned by a quarter first
   always_comb begin
      px_ext       = qhe_pkg::vec_type'(px_ff);
      py_ext       = qhe_pkg::vec_type'(py_ff);
      pre_degen_in = (px_ff == '0) && (py_ff == '0);
      if (px_ff[qhe_pkg::SUM_W-1]) begin
         if (!py_ff[qhe_pkg::SUM_W-1]) begin
            pre_x_in = py_ext;
            pre_y_in = -px_ext;
            pre_z_in = qhe_pkg::HALF_PI;
         end else begin
            pre_x_in = -py_ext;
            pre_y_in = px_ext;
            pre_z_in = -qhe_pkg::HALF_PI;
         end
      end else begin
         pre_x_in = px_ext;
         pre_y_in = py_ext;
         pre_z_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_tag_ff.valid <= 1'b0;
      end else begin
         pre_tag_ff.valid <= sum_valid_ff;
      end
      pre_tag_ff.degenerate <= pre_degen_in;
      pre_x_ff              <= pre_x_in;
      pre_y_ff              <= pre_y_in;
      pre_z_ff              <= pre_z_in;
   end

   // heading angle in q2.30
   qhe_vectoring u_vectoring (
      .clock   (clock),
      .reset   (reset),
      .in_tag  (pre_tag_ff),
      .in_x    (pre_x_ff),
      .in_y    (pre_y_ff),
      .in_z    (pre_z_ff),
      .out_tag (vec_tag),
      .out_z   (vec_ang)
   );

   // cosine and sine of half the heading, angle carried alongside
   qhe_rotation u_rotation (
      .clock   (clock),
      .reset   (reset),
      .in_tag  (vec_tag),
      .in_ang  (vec_ang),
      .out_tag (rot_tag),
      .out_ang (rot_ang),
      .out_cos (rot_cos),
      .out_sin (rot_sin)
   );

   // round half up, then clamp to the field ranges
   always_comb begin
      ang_sum = rot_ang + qhe_pkg::ANGLE_ROUND;
      ang_rnd = ang_sum >>> qhe_pkg::ANGLE_SHIFT;
      cos_sum = rot_cos + qhe_pkg::UNIT_ROUND;
      cos_rnd = cos_sum >>> qhe_pkg::UNIT_SHIFT;
      sin_sum = rot_sin + qhe_pkg::UNIT_ROUND;
      sin_rnd = sin_sum >>> qhe_pkg::UNIT_SHIFT;

      if (ang_rnd > qhe_pkg::ang_type'(qhe_pkg::ANGLE_MAX)) begin
         heading_in = 16'(qhe_pkg::ANGLE_MAX);
      end else if (ang_rnd < -qhe_pkg::ang_type'(qhe_pkg::ANGLE_MAX)) begin
         heading_in = -16'(qhe_pkg::ANGLE_MAX);
      end else begin
         heading_in = ang_rnd[15:0];
      end

      if (cos_rnd[qhe_pkg::ROT_W-1]) begin
         yaw_w_in = '0;
      end else if (cos_rnd > qhe_pkg::rot_type'(qhe_pkg::UNIT_MAX)) begin
         yaw_w_in = 15'(qhe_pkg::UNIT_MAX);
      end else begin
         yaw_w_in = cos_rnd[14:0];
      end

      if (sin_rnd > qhe_pkg::rot_type'(qhe_pkg::UNIT_MAX)) begin
         yaw_z_in = 16'(qhe_pkg::UNIT_MAX);
      end else if (sin_rnd < -qhe_pkg::rot_type'(qhe_pkg::UNIT_MAX)) begin
         yaw_z_in = -16'(qhe_pkg::UNIT_MAX);
      end else begin
         yaw_z_in = sin_rnd[15:0];
      end

      // vertical sensor axis: identity quaternion
      if (rot_tag.degenerate) begin
         heading_in = '0;
         yaw_w_in   = 15'(qhe_pkg::UNIT_MAX);
         yaw_z_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rot_tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      yaw_w_ff   <= yaw_w_in;
      yaw_z_ff   <= yaw_z_in;
      heading_ff <= heading_in;
      degen_ff   <= rot_tag.degenerate;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_yaw_w         = yaw_w_ff;
   assign rsp_yaw_z         = yaw_z_ff;
   assign rsp_heading_angle = heading_ff;
   assign rsp_degenerate    = degen_ff;

   // every request transfer gives a result once it has passed the whole pipeline
   `QHE_ASSERT_IMPLY(a_fixed_latency, clock, reset, start, ##(qhe_pkg::LATENCY) rsp_valid)

   // no result without a request transfer at the matching cycle
   `QHE_ASSERT_ALWAYS(a_no_spurious, clock, reset, !rsp_valid || $past(start, qhe_pkg::LATENCY))

   // a vertical axis comes out as the identity
   `QHE_ASSERT_IMPLY(a_identity, clock, reset, rsp_valid && rsp_degenerate,
      rsp_yaw_w == qhe_pkg::UNIT_MAX && rsp_yaw_z == '0 && rsp_heading_angle == '0)

   // clamping keeps angle and sine inside their ranges
   `QHE_ASSERT_IMPLY(a_result_range, clock, reset, rsp_valid,
      rsp_heading_angle <= qhe_pkg::ANGLE_MAX && rsp_heading_angle >= -qhe_pkg::ANGLE_MAX
      && rsp_yaw_z <= qhe_pkg::UNIT_MAX && rsp_yaw_z >= -qhe_pkg::UNIT_MAX)

endmodule

// File: test/quaternion_heading_extract_checker.sv
// checker for the heading extract: predicts each yaw quaternion and compares results in order
`timescale 1ns / 1ps

module quaternion_heading_extract_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic               rsp_valid,
   input  logic        [14:0] rsp_yaw_w,
   input  logic signed [15:0] rsp_yaw_z,
   input  logic signed [15:0] rsp_heading_angle,
   input  logic               rsp_degenerate,
   output int                 failures,
   output int                 pending_results
);

   localparam int ROUNDS = (qhe_pkg::CORDIC_STEPS < 24) ? qhe_pkg::CORDIC_STEPS : 24;
   localparam longint QUARTER_TURN = 64'h6487ED51;
   localparam longint CORDIC_INV_GAIN = 64'h26DD3B6A;
   localparam longint HEADING_LIMIT = 25736;
   localparam longint UNIT_LIMIT = 32767;

   // atan(2^-i) in q2.30, truncated
   localparam longint ARCTAN_Q30 [24] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
      64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
      64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
   };

   typedef struct {
      logic        [14:0] yaw_w;
      logic signed [15:0] yaw_z;
      logic signed [15:0] angle;
      logic               degenerate;
   } yaw_quat_type;

   yaw_quat_type yaw_expected_q [$];
   int fail_total = 0;

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic yaw_quat_type predict_yaw(input logic signed [15:0] qw, qx, qy, qz);
      longint px, py, vx, vy, va, tmp, dx, dy, rx, ry, rr;
      yaw_quat_type res;
      px = ((longint'(qx) * longint'(qz)) >>> qhe_pkg::PROD_SHIFT)
         + ((longint'(qw) * longint'(qy)) >>> qhe_pkg::PROD_SHIFT);
      py = ((longint'(qy) * longint'(qz)) >>> qhe_pkg::PROD_SHIFT)
         - ((longint'(qw) * longint'(qx)) >>> qhe_pkg::PROD_SHIFT);
      // vertical axis: no heading, identity result
      if (px == 0 && py == 0) begin
         res.yaw_w = 15'(UNIT_LIMIT);
         res.yaw_z = '0;
         res.angle = '0;
         res.degenerate = 1'b1;
         return res;
      end
      // vectoring, left half plane turned into the right one first
      vx = px;
      vy = py;
      va = 0;
      if (vx < 0) begin
         if (vy >= 0) begin
            tmp = vx; vx = vy; vy = -tmp; va = QUARTER_TURN;
         end else begin
            tmp = vx; vx = -vy; vy = tmp; va = -QUARTER_TURN;
         end
      end
      for (int i = 0; i < ROUNDS; i++) begin
         dx = vy >>> i;
         dy = vx >>> i;
         if (vy >= 0) begin
            vx += dx; vy -= dy; va += ARCTAN_Q30[i];
         end else begin
            vx -= dx; vy += dy; va -= ARCTAN_Q30[i];
         end
      end
      // rotation by the half angle
      rr = va >>> 1;
      rx = CORDIC_INV_GAIN;
      ry = 0;
      for (int i = 0; i < ROUNDS; i++) begin
         dx = ry >>> i;
         dy = rx >>> i;
         if (rr >= 0) begin
            rx -= dx; ry += dy; rr -= ARCTAN_Q30[i];
         end else begin
            rx += dx; ry -= dy; rr += ARCTAN_Q30[i];
         end
      end
      res.angle = 16'(clip((va + (64'sd1 <<< 16)) >>> 17, -HEADING_LIMIT, HEADING_LIMIT));
      res.yaw_w = 15'(clip((rx + (64'sd1 <<< 14)) >>> 15, 0, UNIT_LIMIT));
      res.yaw_z = 16'(clip((ry + (64'sd1 <<< 14)) >>> 15, -UNIT_LIMIT, UNIT_LIMIT));
      res.degenerate = 1'b0;
      return res;
   endfunction

   always @(posedge clock) begin
      yaw_quat_type want;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            if (yaw_expected_q.size() == 0) begin
               fail_total++;
               if (fail_total <= 10)
                  $display("unexpected result: w=%0d z=%0d angle=%0d degenerate=%0b",
                           rsp_yaw_w, rsp_yaw_z, rsp_heading_angle, rsp_degenerate);
            end else begin
               want = yaw_expected_q.pop_front();
               if (rsp_yaw_w !== want.yaw_w || rsp_yaw_z !== want.yaw_z ||
                   rsp_heading_angle !== want.angle || rsp_degenerate !== want.degenerate) begin
                  fail_total++;
                  if (fail_total <= 10)
                     $display({"mismatch: expected w=%0d z=%0d angle=%0d degenerate=%0b,",
                               " got w=%0d z=%0d angle=%0d degenerate=%0b"},
                              want.yaw_w, want.yaw_z, want.angle, want.degenerate,
                              rsp_yaw_w, rsp_yaw_z, rsp_heading_angle, rsp_degenerate);
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0)
            yaw_expected_q.push_back(predict_yaw(req_quat_w, req_quat_x, req_quat_y, req_quat_z));
      end
      failures <= fail_total;
      pending_results <= yaw_expected_q.size();
   end

endmodule

// File: test/quaternion_heading_extract_tb.sv
// testbench top for the heading extract: stimulus, clock, reset and the final verdict
`timescale 1ns / 1ps

module quaternion_heading_extract_tb;

   // clock and synchronous reset, every input known from time zero
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic signed [15:0] req_quat_w = '0;
   logic signed [15:0] req_quat_x = '0;
   logic signed [15:0] req_quat_y = '0;
   logic signed [15:0] req_quat_z = '0;

   logic               busy;
   logic               rsp_valid;
   logic        [14:0] rsp_yaw_w;
   logic signed [15:0] rsp_yaw_z;
   logic signed [15:0] rsp_heading_angle;
   logic               rsp_degenerate;

   int failures;
   int pending_results;

   // longest idle stretch the sender draws between transfers, 0 means back to back
   int gap_max = 9;

   always #5 clock = ~clock;

   quaternion_heading_extract dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_quat_w        (req_quat_w),
      .req_quat_x        (req_quat_x),
      .req_quat_y        (req_quat_y),
      .req_quat_z        (req_quat_z),
      .rsp_valid         (rsp_valid),
      .rsp_yaw_w         (rsp_yaw_w),
      .rsp_yaw_z         (rsp_yaw_z),
      .rsp_heading_angle (rsp_heading_angle),
      .rsp_degenerate    (rsp_degenerate)
   );

   // watches both channels, predicts every result and counts failures
   quaternion_heading_extract_checker yaw_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_quat_w        (req_quat_w),
      .req_quat_x        (req_quat_x),
      .req_quat_y        (req_quat_y),
      .req_quat_z        (req_quat_z),
      .rsp_valid         (rsp_valid),
      .rsp_yaw_w         (rsp_yaw_w),
      .rsp_yaw_z         (rsp_yaw_z),
      .rsp_heading_angle (rsp_heading_angle),
      .rsp_degenerate    (rsp_degenerate),
      .failures          (failures),
      .pending_results   (pending_results)
   );

   // one quaternion transfer, then a drawn idle gap
   // start stays high when the gap is zero so back to back transfers never glitch it
   task automatic send_quat(input logic signed [15:0] qw, qx, qy, qz);
      int gap;
      gap = $urandom_range(0, gap_max);
      req_quat_w <= qw;
      req_quat_x <= qx;
      req_quat_y <= qy;
      req_quat_z <= qz;
      start <= 1'b1;
      @(posedge clock);
      // transfer happens at the first edge that sees busy low
      while (busy !== 1'b0) @(posedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold the sender off until the pipeline has delivered everything
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   // values at the edges of the q1.15 range
   function automatic logic signed [15:0] edge_sample();
      case ($urandom_range(0, 5))
         0: return -16'sd32768;
         1: return -16'sd32767;
         2: return -16'sd1;
         3: return 16'sd0;
         4: return 16'sd1;
         default: return 16'sd32767;
      endcase
   endfunction

   initial begin
      logic signed [15:0] qw, qx, qy, qz;
      int kind;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      send_quat(0, 0, 0, 0);                  // zero quaternion, vertical
      send_quat(32767, 0, 0, 0);              // identity, vertical
      send_quat(1234, 0, 0, -20000);          // pure yaw keeps the axis vertical
      send_quat(0, 1, 0, 0);                  // flip about x, axis points down
      send_quat(1, 0, 0, 0);                  // tiny scalar only
      send_quat(23170, 23170, 0, 0);          // heading minus a quarter turn
      send_quat(23170, -23170, 0, 0);         // heading plus a quarter turn
      send_quat(23170, 0, 23170, 0);          // heading zero
      send_quat(23170, 0, -23170, 0);         // negative x axis, angle clamps near pi
      send_quat(0, 23170, 0, 23170);
      send_quat(0, -23170, 0, 23170);         // negative x axis by the cross term
      send_quat(20000, 10000, -15000, 5000);  // left half plane, below the axis
      send_quat(20000, -10000, -15000, 5000); // left half plane, above the axis
      send_quat(-32768, -32768, -32768, -32768);
      send_quat(32767, 32767, 32767, 32767);
      send_quat(-32768, 32767, -32768, 32767);
      send_quat(32767, -32768, 32767, -32768);
      send_quat(-32768, -32768, 32767, 32767);
      send_quat(0, 0, 1, 1);                  // smallest projection straight up
      send_quat(1, 1, 0, 0);                  // smallest projection straight down
      send_quat(0, -1, 0, 1);                 // smallest projection along minus x
      send_quat(-1, 1, 1, 0);
      send_quat(16384, 16384, 16384, 16384);
      send_quat(32767, -1, 32767, -1);

      // pause until every directed result is back
      drain_results();

      // random part, in segments that either idle or run back to back
      for (int seg = 0; seg < 12; seg++) begin
         gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
         for (int n = 0; n < 50; n++) begin
            kind = $urandom_range(0, 9);
            qw = 16'($urandom);
            qx = 16'($urandom);
            qy = 16'($urandom);
            qz = 16'($urandom);
            case (kind)
               6: begin
                  // vertical axis with random scalar and z
                  qx = '0;
                  qy = '0;
               end
               7: begin
                  // tiny components, lots of exact zeros in the projection
                  qw = 16'(int'($urandom_range(0, 8)) - 4);
                  qx = 16'(int'($urandom_range(0, 8)) - 4);
                  qy = 16'(int'($urandom_range(0, 8)) - 4);
                  qz = 16'(int'($urandom_range(0, 8)) - 4);
               end
               8: begin
                  qw = edge_sample();
                  qx = edge_sample();
                  qy = edge_sample();
                  qz = edge_sample();
               end
               9: begin
                  // one component zero, projection on an axis more often
                  case ($urandom_range(0, 3))
                     0: qw = '0;
                     1: qx = '0;
                     2: qy = '0;
                     default: qz = '0;
                  endcase
               end
               default: ;
            endcase
            send_quat(qw, qx, qy, qz);
         end
         if (seg == 5)
            drain_results();
      end

      // wait for the last results, then more than a pipeline depth for strays
      drain_results();
      repeat (qhe_pkg::LATENCY + 8) @(posedge clock);

      if (failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

endmodule
